// File: src/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg: shared types and constants of the utf-8 stream decoder
// Byte class masks, the substitute character and the result queue entry types.
// ----------------------------------------------------------------------------
package u8sd_pkg;

   localparam int unsigned INDEX_BITS_DEFAULT = 16;

   localparam int unsigned BYTE_BITS  = 8;
   localparam int unsigned CP_BITS    = 21;
   localparam int unsigned CIDX_BITS  = 16;
   localparam int unsigned EXP_BITS   = 2;
   localparam int unsigned REQ_TDATA_BITS = 8;
   localparam int unsigned RSP_TDATA_BITS = 40;

   localparam logic [CP_BITS-1:0] SUBST_CHAR = 21'h00003F;

   // leading-bit masks and their match values
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_MATCH = 8'h80;
   localparam logic [7:0] LEAD2_MASK  = 8'hE0;
   localparam logic [7:0] LEAD2_MATCH = 8'hC0;
   localparam logic [7:0] LEAD3_MASK  = 8'hF0;
   localparam logic [7:0] LEAD3_MATCH = 8'hE0;
   localparam logic [7:0] LEAD4_MASK  = 8'hF8;
   localparam logic [7:0] LEAD4_MATCH = 8'hF0;

   localparam logic [EXP_BITS-1:0] EXP_NONE = 2'd0;
   localparam logic [EXP_BITS-1:0] EXP_ONE  = 2'd1;
   localparam logic [EXP_BITS-1:0] EXP_TWO  = 2'd2;
   localparam logic [EXP_BITS-1:0] EXP_THREE = 2'd3;

   typedef struct packed {
      logic [CP_BITS-1:0]   code_point;
      logic                 replaced;
      logic [CIDX_BITS-1:0] char_pos;
   } result_type;

   // one queue entry holds all results of one byte
   typedef struct packed {
      logic       two;
      result_type res0;
      result_type res1;
   } entry_type;

endpackage

// File: src/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder: streaming utf-8 to code point decoder
// Decodes one byte a cycle while the result queue has room, gives 0 to 2 code
// points per byte tagged with their character index.
// ----------------------------------------------------------------------------
//   channel   direction  tdata                         tuser      tlast
//   req_      in         byte_value[7:0]               -          text_end
//   rsp_      out        code_point[20:0],             replaced   run_last
//                        char_pos[36:21], zero pad
//
// one byte is taken every cycle while the two-entry result queue has room;
// a byte that gives two code points is sent as two rsp transfers from one entry.
// the results of a taken byte are registered into the queue before rsp_ shows them.
// reset clears decoder state, character index and the result queue.
// req_tready depends only on registered queue state, never on rsp_tready.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
   parameter int unsigned INDEX_BITS = u8sd_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [u8sd_pkg::REQ_TDATA_BITS-1:0] req_tdata,  // byte_value[7:0]
   input  logic                                req_tlast,  // text_end
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [u8sd_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,  // code_point[20:0],
                                                           // char_pos[36:21], pad
   output logic                                rsp_tuser,  // replaced
   output logic                                rsp_tlast   // run_last
);

   logic [u8sd_pkg::EXP_BITS-1:0] exp_ff, exp_in;
   logic [u8sd_pkg::CP_BITS-1:0]  partial_ff, partial_in;
   logic [INDEX_BITS-1:0]         idx_ff, idx_in;

   u8sd_pkg::entry_type q_ff [2];
   u8sd_pkg::entry_type q0_in, q1_in;
   logic [1:0]          q_valid_ff, q_valid_in;
   logic                sel_ff;

   logic [7:0]  b;
   logic        req_acc;
   logic        pend, is_cont, is_ascii, is_l2, is_l3, is_l4, is_bad;
   logic        interrupt, cont_emit, fresh_emit, trunc, any_emit, two_emit;
   logic [u8sd_pkg::EXP_BITS-1:0] exp_dec, exp_after;
   logic [u8sd_pkg::CP_BITS-1:0]  partial_shift, fresh_cp;
   logic [INDEX_BITS-1:0]         idx_plus1;
   u8sd_pkg::entry_type           new_entry;
   u8sd_pkg::result_type          head_res;
   logic        head_last, pop, push;

   assign b       = req_tdata[7:0];
   assign req_acc = req_tvalid && req_tready;

   // byte classification
   always_comb begin
      pend     = (exp_ff != u8sd_pkg::EXP_NONE);
      is_ascii = !b[7];
      is_cont  = (b & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_MATCH;
      is_l2    = (b & u8sd_pkg::LEAD2_MASK) == u8sd_pkg::LEAD2_MATCH;
      is_l3    = (b & u8sd_pkg::LEAD3_MASK) == u8sd_pkg::LEAD3_MATCH;
      is_l4    = (b & u8sd_pkg::LEAD4_MASK) == u8sd_pkg::LEAD4_MATCH;
      is_bad   = b[7] && !is_cont && !is_l2 && !is_l3 && !is_l4;
   end

   // decode of one byte against the pending sequence
   always_comb begin
      partial_shift = {partial_ff[u8sd_pkg::CP_BITS-7:0], b[5:0]};
      exp_dec       = exp_ff - u8sd_pkg::EXP_ONE;
      interrupt     = pend && !is_cont;
      cont_emit     = pend && is_cont && (exp_ff == u8sd_pkg::EXP_ONE);
      fresh_emit    = (!pend || !is_cont) && (is_ascii || is_bad);
      fresh_cp      = is_ascii ? {13'd0, b} : u8sd_pkg::SUBST_CHAR;

      exp_after  = u8sd_pkg::EXP_NONE;
      partial_in = '0;
      if (pend && is_cont) begin
         exp_after  = exp_dec;
         partial_in = cont_emit ? '0 : partial_shift;
      end else if (is_l2) begin
         exp_after  = u8sd_pkg::EXP_ONE;
         partial_in = {16'd0, b[4:0]};
      end else if (is_l3) begin
         exp_after  = u8sd_pkg::EXP_TWO;
         partial_in = {17'd0, b[3:0]};
      end else if (is_l4) begin
         exp_after  = u8sd_pkg::EXP_THREE;
         partial_in = {18'd0, b[2:0]};
      end
      trunc    = req_tlast && (exp_after != u8sd_pkg::EXP_NONE);
      any_emit = interrupt || cont_emit || fresh_emit || trunc;
      two_emit = interrupt && (fresh_emit || trunc);

      idx_plus1 = idx_ff + INDEX_BITS'(1);
      new_entry.two           = two_emit;
      new_entry.res0.char_pos = u8sd_pkg::CIDX_BITS'(idx_ff);
      new_entry.res1.char_pos = u8sd_pkg::CIDX_BITS'(idx_plus1);
      if (interrupt || trunc) begin
         new_entry.res0.code_point = u8sd_pkg::SUBST_CHAR;
         new_entry.res0.replaced   = 1'b1;
      end else if (cont_emit) begin
         new_entry.res0.code_point = partial_shift;
         new_entry.res0.replaced   = 1'b0;
      end else begin
         new_entry.res0.code_point = fresh_cp;
         new_entry.res0.replaced   = is_bad;
      end
      if (fresh_emit) begin
         new_entry.res1.code_point = fresh_cp;
         new_entry.res1.replaced   = is_bad;
      end else begin
         new_entry.res1.code_point = u8sd_pkg::SUBST_CHAR;
         new_entry.res1.replaced   = 1'b1;
      end

      exp_in = exp_after;
      if (!any_emit) begin
         idx_in = idx_ff;
      end else if (two_emit) begin
         idx_in = idx_plus1 + INDEX_BITS'(1);
      end else begin
         idx_in = idx_plus1;
      end
      if (req_tlast) begin
         exp_in     = u8sd_pkg::EXP_NONE;
         partial_in = '0;
         idx_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff     <= u8sd_pkg::EXP_NONE;
         partial_ff <= '0;
         idx_ff     <= '0;
      end else if (req_acc) begin
         exp_ff     <= exp_in;
         partial_ff <= partial_in;
         idx_ff     <= idx_in;
      end
   end

   // result queue, head at slot 0
   assign req_tready = !q_valid_ff[1];
   assign head_res   = sel_ff ? q_ff[0].res1 : q_ff[0].res0;
   assign head_last  = sel_ff || !q_ff[0].two;
   assign pop        = q_valid_ff[0] && rsp_tready && head_last;
   assign push       = req_acc && any_emit;

   always_comb begin
      q_valid_in = q_valid_ff;
      q0_in      = q_ff[0];
      q1_in      = q_ff[1];
      if (pop) begin
         q_valid_in = {1'b0, q_valid_ff[1]};
         q0_in      = q_ff[1];
      end
      // new entry goes behind whatever is left after the pop
      if (push) begin
         if (q_valid_in[0]) begin
            q_valid_in[1] = 1'b1;
            q1_in         = new_entry;
         end else begin
            q_valid_in[0] = 1'b1;
            q0_in         = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 2'b00;
         sel_ff     <= 1'b0;
      end else begin
         q_valid_ff <= q_valid_in;
         if (pop) begin
            sel_ff <= 1'b0;
         end else if (q_valid_ff[0] && rsp_tready) begin
            sel_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q0_in;
      q_ff[1] <= q1_in;
   end

   assign rsp_tvalid = q_valid_ff[0];
   assign rsp_tdata  = {3'd0, head_res.char_pos, head_res.code_point};
   assign rsp_tuser  = head_res.replaced;
   assign rsp_tlast  = head_last;

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      q_valid_ff[1] |-> q_valid_ff[0])
      else $error("queue slot 1 valid while head empty");

   a_sel_two: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> (q_valid_ff[0] && q_ff[0].two))
      else $error("second result selected on a single-result entry");

   a_text_end_clear: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tlast) |=> (exp_ff == u8sd_pkg::EXP_NONE && idx_ff == '0))
      else $error("state not cleared after text end");

   a_partial_idle: assert property (@(posedge clock) disable iff (reset)
      (exp_ff == u8sd_pkg::EXP_NONE) |-> (partial_ff == '0))
      else $error("partial value left over with nothing pending");

endmodule

// File: tb/sv/utf8_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb: self-checking bench of the utf-8 stream decoder
// Feeds byte streams (corner bytes, a long text sent with no idling, then
// random well-formed, broken and noisy text), decodes each accepted byte in
// a local predictor and compares every code point leaving the block against
// the oldest predicted one.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;

   localparam int QUIET_LIMIT = 5000;
   localparam int LONG_CHARS  = 200;

   typedef struct {
      logic [u8sd_pkg::CP_BITS-1:0]   code_point;
      logic                           replaced;
      logic [u8sd_pkg::CIDX_BITS-1:0] char_pos;
      logic                           run_last;
   } char_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [u8sd_pkg::REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic                                req_tlast = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [u8sd_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                                rsp_tuser;
   logic                                rsp_tlast;

   // decoder state mirrored by the predictor
   logic [u8sd_pkg::EXP_BITS-1:0]  cont_left = u8sd_pkg::EXP_NONE;
   logic [u8sd_pkg::CP_BITS-1:0]   partial_cp = '0;
   logic [u8sd_pkg::CIDX_BITS-1:0] char_count = '0;

   char_result_type expected_chars[$];
   char_result_type step_out[2];
   int              step_n;

   bit stall_en = 1'b1;
   int failures = 0;
   int bytes_sent = 0;
   int texts_ended = 0;
   int chars_checked = 0;
   int substitutes_seen = 0;
   int quiet_cycles = 0;

   utf8_stream_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   task emit_char(input logic [u8sd_pkg::CP_BITS-1:0] cp, input logic bad);
      step_out[step_n].code_point = cp;
      step_out[step_n].replaced   = bad;
      step_out[step_n].char_pos   = char_count;
      step_out[step_n].run_last   = 1'b0;
      step_n++;
      char_count++;
   endtask

   // byte seen with no sequence pending
   task start_char(input logic [7:0] b);
      if (!b[7]) begin
         emit_char({13'd0, b}, 1'b0);
      end else if ((b & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_MATCH) begin
         // stray continuation, dropped
      end else if ((b & u8sd_pkg::LEAD2_MASK) == u8sd_pkg::LEAD2_MATCH) begin
         partial_cp = {16'd0, b[4:0]};
         cont_left  = u8sd_pkg::EXP_ONE;
      end else if ((b & u8sd_pkg::LEAD3_MASK) == u8sd_pkg::LEAD3_MATCH) begin
         partial_cp = {17'd0, b[3:0]};
         cont_left  = u8sd_pkg::EXP_TWO;
      end else if ((b & u8sd_pkg::LEAD4_MASK) == u8sd_pkg::LEAD4_MATCH) begin
         partial_cp = {18'd0, b[2:0]};
         cont_left  = u8sd_pkg::EXP_THREE;
      end else begin
         emit_char(u8sd_pkg::SUBST_CHAR, 1'b1);
      end
   endtask

   task decode_byte(input logic [7:0] b, input logic text_end);
      step_n = 0;
      if (cont_left != u8sd_pkg::EXP_NONE) begin
         if ((b & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_MATCH) begin
            partial_cp = {partial_cp[u8sd_pkg::CP_BITS-7:0], b[5:0]};
            cont_left  = cont_left - u8sd_pkg::EXP_ONE;
            if (cont_left == u8sd_pkg::EXP_NONE) begin
               emit_char(partial_cp, 1'b0);
               partial_cp = '0;
            end
         end else begin
            // interrupted sequence: substitute, then decode this byte afresh
            emit_char(u8sd_pkg::SUBST_CHAR, 1'b1);
            cont_left  = u8sd_pkg::EXP_NONE;
            partial_cp = '0;
            start_char(b);
         end
      end else begin
         start_char(b);
      end
      if (text_end && cont_left != u8sd_pkg::EXP_NONE && step_n < 2)
         emit_char(u8sd_pkg::SUBST_CHAR, 1'b1);
      if (step_n > 0)
         step_out[step_n-1].run_last = 1'b1;
      for (int i = 0; i < step_n; i++)
         expected_chars.insert(expected_chars.size(), step_out[i]);
      if (text_end) begin
         cont_left  = u8sd_pkg::EXP_NONE;
         partial_cp = '0;
         char_count = '0;
         texts_ended++;
      end
   endtask

   // ---------------------------------------------------------------- byte side

   task send_byte(input logic [7:0] b, input logic text_end);
      while (stall_en && $urandom_range(0, 99) < 13) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= text_end;
      do @(posedge clock); while (!req_tready);
      decode_byte(b, text_end);
      bytes_sent++;
   endtask

   // lead byte of a len-byte character followed by n_cont continuation bytes
   task send_seq(input int len, input int n_cont);
      logic [7:0] lead;
      lead = 8'($urandom);
      case (len)
         1: lead[7]   = 1'b0;
         2: lead[7:5] = 3'b110;
         3: lead[7:4] = 4'b1110;
         default: lead[7:3] = 5'b11110;
      endcase
      send_byte(lead, $urandom_range(0, 99) < 3);
      for (int i = 0; i < n_cont; i++)
         send_byte({2'b10, 6'($urandom)}, $urandom_range(0, 99) < 3);
   endtask

   // ---------------------------------------------------------------- code point side

   always @(posedge clock) begin : rsp_side
      char_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected code point %h at index %0d",
                   rsp_tdata[u8sd_pkg::CP_BITS-1:0],
                   rsp_tdata[u8sd_pkg::CP_BITS +: u8sd_pkg::CIDX_BITS]);
            failures++;
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (want.replaced)
               substitutes_seen++;
            if (rsp_tdata[u8sd_pkg::CP_BITS-1:0] !== want.code_point) begin
               $error("code_point expected %h got %h", want.code_point,
                      rsp_tdata[u8sd_pkg::CP_BITS-1:0]);
               failures++;
            end
            if (rsp_tuser !== want.replaced) begin
               $error("replaced expected %b got %b", want.replaced, rsp_tuser);
               failures++;
            end
            if (rsp_tdata[u8sd_pkg::CP_BITS +: u8sd_pkg::CIDX_BITS] !== want.char_pos) begin
               $error("char_pos expected %0d got %0d", want.char_pos,
                      rsp_tdata[u8sd_pkg::CP_BITS +: u8sd_pkg::CIDX_BITS]);
               failures++;
            end
            if (rsp_tlast !== want.run_last) begin
               $error("run_last expected %b got %b", want.run_last, rsp_tlast);
               failures++;
            end
         end
      end
      rsp_tready <= !(stall_en && $urandom_range(0, 99) < 13);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no item moved for %0d cycles", QUIET_LIMIT);
            $display("utf8_stream_decoder: mismatch");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task test_corner_bytes;
      stall_en = 1'b1;
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      // largest two, three and four byte forms
      send_byte(8'hDF, 1'b0);  send_byte(8'hBF, 1'b0);
      send_byte(8'hEF, 1'b0);  send_byte(8'hBF, 1'b0);  send_byte(8'hBF, 1'b0);
      send_byte(8'hF7, 1'b0);  send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);  send_byte(8'hBF, 1'b0);
      // overlong zero passes unchecked
      send_byte(8'hC0, 1'b0);  send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);  // stray continuation
      send_byte(8'hFF, 1'b0);  // invalid lead
      send_byte(8'hC3, 1'b0);  send_byte(8'h41, 1'b0);  // cut by ascii
      send_byte(8'hE2, 1'b0);  send_byte(8'hF8, 1'b0);  // cut by invalid lead
      send_byte(8'hE2, 1'b0);  send_byte(8'hC3, 1'b0);  send_byte(8'hA9, 1'b0);
      send_byte(8'hF0, 1'b0);  send_byte(8'h9F, 1'b1);  // text ends mid character
      send_byte(8'hC3, 1'b0);  send_byte(8'hE2, 1'b1);  // cut, then truncated
   endtask

   // no idling here: one long ascii text sent back to back
   task test_long_text;
      stall_en = 1'b0;
      for (int i = 0; i < LONG_CHARS; i++)
         send_byte({1'b0, 7'($urandom)}, i == LONG_CHARS - 1);
   endtask

   task test_random_text(input int n_bytes);
      int stop_at;
      int kind;
      int len;
      stall_en = 1'b1;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         kind = $urandom_range(0, 99);
         len  = $urandom_range(1, 4);
         if (kind < 65)
            send_seq(len, len - 1);
         else if (kind < 80)
            send_seq(len == 1 ? 2 : len, $urandom_range(0, (len == 1 ? 2 : len) - 2));
         else if (kind < 90)
            send_byte({2'b10, 6'($urandom)}, $urandom_range(0, 99) < 3);
         else
            send_byte(8'($urandom), $urandom_range(0, 99) < 3);
      end
      send_byte({1'b0, 7'($urandom)}, 1'b1);
   endtask

   task finish_run;
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d bytes in %0d texts, %0d code points checked, %0d substitutes",
               bytes_sent, texts_ended, chars_checked, substitutes_seen);
      $display("covered all byte classes, cut and truncated sequences, unstalled run");
      if (failures == 0)
         $display("utf8_stream_decoder: match");
      else
         $display("utf8_stream_decoder: mismatch");
      $finish;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_bytes();
      test_long_text();
      test_random_text(870);
      finish_run();
   end

endmodule
